@@ src/lsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the leap-second time converter
// Table geometry, command and status codes, channel payloads, table entry
// layout and the token that walks down the search cell chain.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int TIME_W      = 40;
   localparam int OFF_W       = 8;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   // upper-bound search over n <= TABLE_DEPTH keys needs clog2(n+1) steps
   localparam int NUM_CELLS   = CNT_W;
   localparam int ECNT_W      = 7;
   localparam int CSR_IDX_W   = 1;

   localparam logic [TIME_W-1:0] POSIX_MIN = TIME_W'(63072000);
   localparam logic [TIME_W-1:0] TAI_MIN   = TIME_W'(63072010);
   localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

   localparam logic [1:0] CMD_LOAD         = 2'd0;
   localparam logic [1:0] CMD_POSIX_TO_TAI = 2'd1;
   localparam logic [1:0] CMD_TAI_TO_POSIX = 2'd2;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_NOT_LOADED   = 2'd1;
   localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSIX_EXPIRY = 1'd1;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [5:0]              entry_index;
      logic [TIME_W-1:0]       time_value;
      logic signed [OFF_W-1:0] entry_offset;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] result_time;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]       posix;
      logic [TIME_W-1:0]       tai;
      logic signed [OFF_W-1:0] offset;
   } entry_type;

   // search state handed from cell to cell
   typedef struct packed {
      logic             active;
      logic             sel;     // which read port carries key[mid]
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
   } tok_type;

   typedef struct packed {
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
   } rd_req_type;

endpackage
`default_nettype wire

@@ src/lsc_table_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_table_mem: leap-second table storage
// One write port and two read ports with registered read data. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
module lsc_table_mem (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [lsc_pkg::IDX_W-1:0]  wr_addr,
   input  wire lsc_pkg::entry_type         wr_data,
   input  wire logic [lsc_pkg::IDX_W-1:0]  rd_addr_a,
   input  wire logic [lsc_pkg::IDX_W-1:0]  rd_addr_b,
   output lsc_pkg::entry_type              rd_data_a,
   output lsc_pkg::entry_type              rd_data_b
);

   lsc_pkg::entry_type mem_ff [lsc_pkg::TABLE_DEPTH];
   lsc_pkg::entry_type rd_a_ff;
   lsc_pkg::entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

@@ src/lsc_search_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_search_cell: one step of the upper-bound binary search
// Holds the search range for its step, compares key[mid] against the value
// and requests both possible next midpoints so that the next cell finds its
// key on one of the two read ports.
// ----------------------------------------------------------------------------
module lsc_search_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lsc_pkg::tok_type            tok_i,
   input  wire logic [lsc_pkg::TIME_W-1:0]  key_a,
   input  wire logic [lsc_pkg::TIME_W-1:0]  key_b,
   input  wire logic [lsc_pkg::TIME_W-1:0]  value,
   output lsc_pkg::tok_type                 tok_o,
   output lsc_pkg::rd_req_type              rd_o
);

   lsc_pkg::tok_type            tok_ff;
   logic [lsc_pkg::CNT_W:0]     mid_sum;
   logic [lsc_pkg::CNT_W:0]     lo_sum;
   logic [lsc_pkg::CNT_W:0]     hi_sum;
   logic [lsc_pkg::CNT_W-1:0]   mid;
   logic [lsc_pkg::CNT_W-1:0]   mid_lo;
   logic [lsc_pkg::CNT_W-1:0]   mid_hi;
   logic [lsc_pkg::TIME_W-1:0]  key;
   logic                        open_rng;
   logic                        key_le;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_i;
      end
   end

   assign mid_sum  = {1'b0, tok_ff.lo} + {1'b0, tok_ff.hi};
   assign mid      = mid_sum[lsc_pkg::CNT_W:1];
   // midpoints of the lower and upper halves
   assign lo_sum   = {1'b0, tok_ff.lo} + {1'b0, mid};
   assign hi_sum   = {1'b0, mid} + {1'b0, tok_ff.hi} + (lsc_pkg::CNT_W + 1)'(1);
   assign mid_lo   = lo_sum[lsc_pkg::CNT_W:1];
   assign mid_hi   = hi_sum[lsc_pkg::CNT_W:1];
   assign key      = tok_ff.sel ? key_b : key_a;
   assign open_rng = tok_ff.lo < tok_ff.hi;
   assign key_le   = key <= value;

   always_comb begin
      tok_o = tok_ff;
      if (tok_ff.active && open_rng) begin
         tok_o.sel = key_le;
         if (key_le) begin
            tok_o.lo = mid + lsc_pkg::CNT_W'(1);
         end else begin
            tok_o.hi = mid;
         end
      end
   end

   always_comb begin
      rd_o = '0;
      if (tok_ff.active) begin
         rd_o.addr_a = mid_lo[lsc_pkg::IDX_W-1:0];
         rd_o.addr_b = mid_hi[lsc_pkg::IDX_W-1:0];
      end
   end

endmodule
`default_nettype wire

@@ src/leap_second_time_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leap_second_time_converter: POSIX / TAI conversion over a leap-second table
// Loads table entries and converts times by an upper-bound binary search run
// down a chain of search cells, then applies the found cumulative offset.
//
//   channel  direction  handshake        payload
//   req_     in         valid / ready    lsc_pkg::req_type
//   rsp_     out        valid / ready    lsc_pkg::rsp_type
//   csr_     in         write enable     index, 40-bit data
//
// A convert transfer with a loaded table goes through S_START, the search
// cell chain at one search step per cycle, fed by the two read ports of the
// table memory, then S_FETCH and S_FINISH. A load goes through S_LOAD and a
// convert with no table loaded through S_START to S_FINISH, an ignored
// command straight to S_FINISH; the next item is taken only back in S_IDLE.
// Reset clears control and the config registers; table contents are undefined
// until loaded, with no clearing pass. A held result stalls only the final step.
// ----------------------------------------------------------------------------
module leap_second_time_converter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire lsc_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output lsc_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [lsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lsc_pkg::TIME_W-1:0]        csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_START,
      S_SEARCH,
      S_FETCH,
      S_FINISH
   } state_type;

   state_type                       state_ff;
   lsc_pkg::req_type                item_ff;
   logic [lsc_pkg::ECNT_W-1:0]      count_ff;
   logic [lsc_pkg::TIME_W-1:0]      expiry_ff;
   logic [lsc_pkg::CNT_W-1:0]       ub_ff;
   logic                            first_ff;
   logic [lsc_pkg::OFF_W-1:0]       eoff_last_ff;
   logic [lsc_pkg::TIME_W-1:0]      hi_lim_ff;
   logic                            tai_none_ff;
   logic                            range_bad_ff;
   logic                            rsp_valid_ff;
   lsc_pkg::rsp_type                rsp_data_ff;

   logic [lsc_pkg::CNT_W-1:0]       n_eff;
   logic [lsc_pkg::CNT_W-1:0]       mid0;
   logic [lsc_pkg::CNT_W-1:0]       n_m1;
   logic [lsc_pkg::CNT_W-1:0]       ub_m1;
   logic                            cmd_tai;
   logic                            wr_en;
   lsc_pkg::entry_type              wr_entry;
   logic [lsc_pkg::IDX_W-1:0]       rd_addr_a;
   logic [lsc_pkg::IDX_W-1:0]       rd_addr_b;
   lsc_pkg::entry_type              rd_a;
   lsc_pkg::entry_type              rd_b;
   logic [lsc_pkg::TIME_W-1:0]      key_a;
   logic [lsc_pkg::TIME_W-1:0]      key_b;
   lsc_pkg::tok_type                cell_tok [lsc_pkg::NUM_CELLS+1];
   lsc_pkg::rd_req_type             cell_rd  [lsc_pkg::NUM_CELLS];
   logic [lsc_pkg::NUM_CELLS-1:0]   cell_act;
   lsc_pkg::rd_req_type             chain_rd;
   logic [lsc_pkg::TIME_W+1:0]      lim_sum;
   logic [lsc_pkg::TIME_W+1:0]      v_ext;
   logic [lsc_pkg::TIME_W+1:0]      off_ext;
   logic [lsc_pkg::TIME_W+1:0]      conv_sum;
   logic                            conv_bad;
   logic [lsc_pkg::TIME_W-1:0]      lo_lim;
   logic [lsc_pkg::TIME_W-1:0]      hi_lim;
   logic                            range_bad;
   lsc_pkg::rsp_type                fin;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         expiry_ff <= lsc_pkg::POSIX_MIN;
      end else if (csr_we) begin
         case (csr_index)
            lsc_pkg::CSR_ENTRY_COUNT:  count_ff  <= csr_wdata[lsc_pkg::ECNT_W-1:0];
            lsc_pkg::CSR_POSIX_EXPIRY: expiry_ff <= csr_wdata;
            default:                   count_ff  <= count_ff;
         endcase
      end
   end

   // counts above the table depth act as a full table
   assign n_eff   = (int'(count_ff) > lsc_pkg::TABLE_DEPTH) ?
                    lsc_pkg::CNT_W'(lsc_pkg::TABLE_DEPTH) : lsc_pkg::CNT_W'(count_ff);
   assign mid0    = n_eff >> 1;
   assign n_m1    = n_eff - lsc_pkg::CNT_W'(1);
   assign ub_m1   = ub_ff - lsc_pkg::CNT_W'(1);
   assign cmd_tai = item_ff.cmd == lsc_pkg::CMD_TAI_TO_POSIX;

   // table write on a load transfer
   assign wr_en          = (state_ff == S_LOAD) &&
                           (int'(item_ff.entry_index) < lsc_pkg::TABLE_DEPTH);
   assign wr_entry.posix  = item_ff.time_value;
   assign wr_entry.tai    = item_ff.time_value +
                            {{(lsc_pkg::TIME_W - lsc_pkg::OFF_W){item_ff.entry_offset[lsc_pkg::OFF_W-1]}},
                             item_ff.entry_offset};
   assign wr_entry.offset = item_ff.entry_offset;

   lsc_table_mem u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (lsc_pkg::IDX_W'(item_ff.entry_index)),
      .wr_data   (wr_entry),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign key_a = cmd_tai ? rd_a.tai : rd_a.posix;
   assign key_b = cmd_tai ? rd_b.tai : rd_b.posix;

   // launch the search token: range [0, n), first key on port A
   always_comb begin
      cell_tok[0]        = '0;
      cell_tok[0].active = (state_ff == S_START) && (n_eff != '0);
      cell_tok[0].hi     = n_eff;
   end

   for (genvar k = 0; k < lsc_pkg::NUM_CELLS; k++) begin : g_cell
      lsc_search_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (cell_tok[k]),
         .key_a (key_a),
         .key_b (key_b),
         .value (item_ff.time_value),
         .tok_o (cell_tok[k+1]),
         .rd_o  (cell_rd[k])
      );
      assign cell_act[k] = cell_tok[k+1].active;
   end

   // at most one cell is active; idle cells request address zero
   always_comb begin
      chain_rd = '0;
      for (int k = 0; k < lsc_pkg::NUM_CELLS; k++) begin
         chain_rd.addr_a = chain_rd.addr_a | cell_rd[k].addr_a;
         chain_rd.addr_b = chain_rd.addr_b | cell_rd[k].addr_b;
      end
   end

   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      case (state_ff)
         S_START: begin
            rd_addr_a = mid0[lsc_pkg::IDX_W-1:0];
            rd_addr_b = n_m1[lsc_pkg::IDX_W-1:0];
         end
         S_SEARCH: begin
            rd_addr_a = chain_rd.addr_a;
            rd_addr_b = chain_rd.addr_b;
         end
         S_FETCH, S_FINISH: begin
            rd_addr_a = ub_m1[lsc_pkg::IDX_W-1:0];
         end
         default: begin
            rd_addr_a = '0;
         end
      endcase
   end

   // TAI upper limit: expiry plus last offset, saturated; negative means none
   assign lim_sum = {2'b00, expiry_ff} +
                    {{(lsc_pkg::TIME_W + 2 - lsc_pkg::OFF_W){eoff_last_ff[lsc_pkg::OFF_W-1]}},
                     eoff_last_ff};

   assign lo_lim    = cmd_tai ? lsc_pkg::TAI_MIN : lsc_pkg::POSIX_MIN;
   assign hi_lim    = cmd_tai ? hi_lim_ff : expiry_ff;
   assign range_bad = (cmd_tai && tai_none_ff) || (item_ff.time_value < lo_lim) ||
                      (item_ff.time_value > hi_lim);

   // apply the found offset, subtracting it toward POSIX
   assign v_ext    = {2'b00, item_ff.time_value};
   assign off_ext  = {{(lsc_pkg::TIME_W + 2 - lsc_pkg::OFF_W){rd_a.offset[lsc_pkg::OFF_W-1]}},
                      rd_a.offset};
   assign conv_sum = cmd_tai ? (v_ext - off_ext) : (v_ext + off_ext);
   assign conv_bad = conv_sum[lsc_pkg::TIME_W+1] | conv_sum[lsc_pkg::TIME_W];

   always_comb begin
      fin = '0;
      case (item_ff.cmd)
         lsc_pkg::CMD_POSIX_TO_TAI, lsc_pkg::CMD_TAI_TO_POSIX: begin
            if (n_eff == '0) begin
               fin.status = lsc_pkg::ST_NOT_LOADED;
            end else if (range_bad_ff || (ub_ff == '0) || conv_bad) begin
               fin.status = lsc_pkg::ST_OUT_OF_RANGE;
            end else begin
               fin.result_time = conv_sum[lsc_pkg::TIME_W-1:0];
               fin.status      = lsc_pkg::ST_OK;
            end
         end
         default: begin
            fin = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hi_lim_ff   <= lim_sum[lsc_pkg::TIME_W] ? lsc_pkg::TIME_MAX :
                        lim_sum[lsc_pkg::TIME_W-1:0];
         tai_none_ff <= lim_sum[lsc_pkg::TIME_W+1];
         // drop valid after the transfer unless a new result replaces it
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  case (req_data.cmd)
                     lsc_pkg::CMD_LOAD:         state_ff <= S_LOAD;
                     lsc_pkg::CMD_POSIX_TO_TAI: state_ff <= S_START;
                     lsc_pkg::CMD_TAI_TO_POSIX: state_ff <= S_START;
                     default:                   state_ff <= S_FINISH;
                  endcase
               end
            end
            S_LOAD: begin
               state_ff <= S_FINISH;
            end
            S_START: begin
               if (n_eff == '0) begin
                  state_ff <= S_FINISH;
               end else begin
                  first_ff <= 1'b1;
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               first_ff <= 1'b0;
               // port B carries the last entry in the first search cycle
               if (first_ff) begin
                  eoff_last_ff <= rd_b.offset;
               end
               if (cell_tok[lsc_pkg::NUM_CELLS].active) begin
                  ub_ff    <= cell_tok[lsc_pkg::NUM_CELLS].lo;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               range_bad_ff <= range_bad;
               state_ff     <= S_FINISH;
            end
            S_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= fin;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_one_cell_active : assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_act))
      else $error("more than one search cell active");

   a_token_launch : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START && n_eff != '0) |=> cell_act[0])
      else $error("search token not launched into first cell");

   a_chain_in_search : assert property (@(posedge clock) disable iff (reset)
      (cell_act != '0) |-> (state_ff == S_SEARCH))
      else $error("search cell active outside search");

   a_no_write_in_search : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cell_act == '0))
      else $error("table written during a search");

endmodule
`default_nettype wire

@@ bench/leap_second_time_converter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leap_second_time_converter_checker: result predictor and scoreboard
// Follows the converter's registers and leap-second table from the observed
// csr_ writes and req_ transfers. Predicts one result per request and
// compares every rsp_ transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module leap_second_time_converter_checker
   import lsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata,
   output int                        mismatch_count,
   output int                        pending_results
);

   localparam longint TIME_MAX_L = (longint'(1) << TIME_W) - 1;

   logic [ECNT_W-1:0]       entry_count  = '0;
   logic [TIME_W-1:0]       posix_expiry = POSIX_MIN;
   logic [TIME_W-1:0]       posix_tab [TABLE_DEPTH];
   logic [TIME_W-1:0]       tai_tab   [TABLE_DEPTH];
   logic signed [OFF_W-1:0] off_tab   [TABLE_DEPTH];
   rsp_type                 expected_times [$];

   function automatic rsp_type convert_time(input req_type r);
      rsp_type           res;
      int                n;
      int                lo;
      int                hi;
      int                mid;
      longint            v;
      longint            lo_lim;
      longint            hi_lim;
      longint            shift;
      logic              to_posix;
      logic [TIME_W-1:0] key;
      res = '0;
      v = longint'(r.time_value);
      n = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
      if (r.cmd != CMD_POSIX_TO_TAI && r.cmd != CMD_TAI_TO_POSIX) begin
         return res;
      end
      if (n == 0) begin
         res.status = ST_NOT_LOADED;
         return res;
      end
      to_posix = (r.cmd == CMD_TAI_TO_POSIX);
      if (!to_posix) begin
         lo_lim = longint'(POSIX_MIN);
         hi_lim = longint'(posix_expiry);
      end else begin
         // TAI limit follows the last entry's offset, saturated at full width
         lo_lim = longint'(TAI_MIN);
         hi_lim = longint'(posix_expiry) + longint'(off_tab[n-1]);
         if (hi_lim > TIME_MAX_L) begin
            hi_lim = TIME_MAX_L;
         end
      end
      if (hi_lim < 0 || v < lo_lim || v > hi_lim) begin
         res.status = ST_OUT_OF_RANGE;
         return res;
      end
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         key = to_posix ? tai_tab[mid] : posix_tab[mid];
         if (longint'(key) <= v) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      if (lo == 0) begin
         res.status = ST_OUT_OF_RANGE;
         return res;
      end
      shift = longint'(off_tab[lo-1]);
      if (to_posix) begin
         shift = -shift;
      end
      v = v + shift;
      if (v < 0 || v > TIME_MAX_L) begin
         res.status = ST_OUT_OF_RANGE;
         return res;
      end
      res.result_time = v[TIME_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         entry_count  = '0;
         posix_expiry = POSIX_MIN;
         expected_times.delete();
         pending_results = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ENTRY_COUNT) begin
               entry_count = csr_wdata[ECNT_W-1:0];
            end else if (csr_index == CSR_POSIX_EXPIRY) begin
               posix_expiry = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_times.size() == 0) begin
               mismatch_count++;
               $error("result with no request outstanding: result_time %0d, status %0d",
                      got.result_time, got.status);
            end else begin
               want = expected_times.pop_front();
               if (got.result_time !== want.result_time) begin
                  mismatch_count++;
                  $error("result_time mismatch: expected %0d, actual %0d",
                         want.result_time, got.result_time);
               end
               if (got.status !== want.status) begin
                  mismatch_count++;
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, got.status);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_times.push_back(convert_time(req_data));
            if (req_data.cmd == CMD_LOAD) begin
               posix_tab[req_data.entry_index] = req_data.time_value;
               off_tab[req_data.entry_index]   = req_data.entry_offset;
               tai_tab[req_data.entry_index]   = req_data.time_value +
                  {{(TIME_W-OFF_W){req_data.entry_offset[OFF_W-1]}}, req_data.entry_offset};
            end
         end
         pending_results = expected_times.size();
      end
   end

endmodule

@@ bench/leap_second_time_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leap_second_time_converter_tb: stimulus and verdict for the converter
// Loads leap-second tables, sweeps the register settings between drained
// phases and sends directed then random load, convert and unused requests,
// with random idling on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module leap_second_time_converter_tb;
   import lsc_pkg::*;

   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         RANDOM_ITEMS = 450;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         IDLE_PCT     = 14;
   localparam int         SETTLE_CYCLES = 20;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   req_type              req_data  = '0;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   int                   mismatch_count;
   int                   pending_results;
   int                   cycle_count   = 0;
   int                   random_items  = 0;
   int                   hold_requests = 0;
   bit                   quiet         = 1'b0;
   logic [TIME_W-1:0]    cur_expiry    = POSIX_MIN;
   logic [TIME_W-1:0]    tab_posix [TABLE_DEPTH];
   logic signed [OFF_W-1:0] tab_off [TABLE_DEPTH];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   leap_second_time_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   leap_second_time_converter_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off whenever one is requested
   initial begin : rsp_side
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] tai_key(input int i);
      return tab_posix[i] + TIME_W'(tab_off[i]);
   endfunction

   // Offer one request and return at the edge that transfers it; valid stays
   // high so the next request can follow without a gap.
   task automatic send(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                       input logic [TIME_W-1:0] value, input logic signed [OFF_W-1:0] off);
      req_type item;
      item.cmd          = cmd;
      item.entry_index  = idx;
      item.time_value   = value;
      item.entry_offset = off;
      if (cmd == CMD_LOAD) begin
         tab_posix[idx] = value;
         tab_off[idx]   = off;
      end
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TIME_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input int count, input logic [TIME_W-1:0] expiry);
      logic [TIME_W-1:0] junk;
      junk = rand_time();
      wait_drained();
      // upper data bits are outside the count register; toggle them anyway
      write_register(CSR_ENTRY_COUNT, {junk[TIME_W-1:ECNT_W], ECNT_W'(count)});
      write_register(CSR_POSIX_EXPIRY, expiry);
      cur_expiry  = expiry;
   endtask

   task automatic run_phase(input int phase_no, input int forced_count);
      int                      count;
      int                      eff;
      int                      pick;
      int                      items;
      int                      j;
      int                      delta;
      bit                      sorted;
      longint                  span;
      logic [1:0]              cmd;
      logic [TIME_W-1:0]       base;
      logic [TIME_W-1:0]       step;
      logic [TIME_W-1:0]       expiry;
      logic [TIME_W-1:0]       v;
      logic [TIME_W-1:0]       key;
      logic signed [OFF_W-1:0] off;

      if (forced_count >= 0) begin
         count = forced_count;
      end else begin
         pick = $urandom_range(99);
         if (pick < 60)      count = $urandom_range(8, 1);
         else if (pick < 80) count = $urandom_range(63, 9);
         else if (pick < 92) count = TABLE_DEPTH;
         else if (pick < 96) count = $urandom_range(127, TABLE_DEPTH + 1);
         else                count = 0;
      end
      eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;

      pick = $urandom_range(99);
      if (pick < 70)      base = POSIX_MIN - 3 + TIME_W'($urandom_range(6));
      else if (pick < 85) base = rand_time();
      else                base = TIME_MAX - TIME_W'($urandom_range(1 << 20));
      step   = TIME_W'($urandom_range(1 << $urandom_range(24, 1), 1));
      sorted = ($urandom_range(9) != 0);

      case ($urandom_range(9))
         0:       expiry = '0;
         1:       expiry = TIME_MAX;
         2:       expiry = POSIX_MIN;
         3:       expiry = rand_time();
         default: expiry = base + TIME_W'(eff) * step + TIME_W'($urandom_range(1 << 16));
      endcase
      set_config(count, expiry);

      off = OFF_W'($urandom_range(50) - 10);
      for (j = 0; j < eff; j++) begin
         v = sorted ? base + TIME_W'(j) * step : rand_time();
         if ($urandom_range(3) == 0) begin
            off = OFF_W'($urandom);
         end else begin
            off = off + OFF_W'($urandom_range(1));
         end
         send(CMD_LOAD, IDX_W'(j), v, off);
         random_items++;
      end

      // stall the result side while requests keep coming
      if (phase_no == 2) begin
         hold_requests++;
      end

      items = $urandom_range(40, 15);
      repeat (items) begin
         pick  = $urandom_range(99);
         delta = $urandom_range(4) - 2;
         if (pick < 8) begin
            j = $urandom_range(TABLE_DEPTH - 1);
            send(CMD_LOAD, IDX_W'(j), base + TIME_W'(j) * step + TIME_W'(delta),
                 OFF_W'($urandom));
            random_items++;
         end else if (pick < 12) begin
            send(CMD_UNUSED, IDX_W'($urandom), rand_time(), OFF_W'($urandom));
         end else begin
            cmd = $urandom_range(1) ? CMD_POSIX_TO_TAI : CMD_TAI_TO_POSIX;
            j   = (eff > 0) ? $urandom_range(eff - 1) : 0;
            if (eff == 0)                     key = base;
            else if (cmd == CMD_POSIX_TO_TAI) key = tab_posix[j];
            else                              key = tai_key(j);
            case ($urandom_range(9))
               0, 1, 2, 3, 4: v = key + TIME_W'(delta);
               5: v = ((cmd == CMD_POSIX_TO_TAI) ? POSIX_MIN : TAI_MIN) + TIME_W'(delta);
               6: begin
                  if (cmd == CMD_POSIX_TO_TAI || eff == 0) v = cur_expiry;
                  else v = cur_expiry + TIME_W'(tab_off[eff-1]);
                  v = v + TIME_W'(delta);
               end
               7: v = rand_time();
               8: begin
                  span = longint'(cur_expiry) - longint'(POSIX_MIN) + 1;
                  if (span > 0) v = POSIX_MIN + TIME_W'(longint'(rand_time()) % span);
                  else          v = rand_time();
               end
               default: v = TIME_MAX - TIME_W'($urandom_range(200));
            endcase
            send(cmd, IDX_W'($urandom), v, OFF_W'($urandom));
            random_items++;
         end
      end
   endtask

   initial begin : stimulus
      int phase_no;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // registers still at reset: no table loaded
      send(CMD_POSIX_TO_TAI, '0, POSIX_MIN, '0);
      send(CMD_TAI_TO_POSIX, '0, TAI_MIN, '0);

      send(CMD_LOAD, IDX_W'(0), TIME_W'(63072000), 8'sd10);
      send(CMD_LOAD, IDX_W'(1), TIME_W'(78796800), 8'sd11);
      send(CMD_LOAD, IDX_W'(2), TIME_W'(94694400), 8'sd12);
      send(CMD_LOAD, IDX_W'(3), TIME_W'(126230400), 8'sd13);
      send(CMD_LOAD, IDX_W'(TABLE_DEPTH - 1), TIME_MAX, -8'sd1);
      set_config(4, TIME_W'(200000000));

      // range edges, entry boundary and a value beyond the last entry
      send(CMD_POSIX_TO_TAI, '0, POSIX_MIN - 1, '0);
      send(CMD_POSIX_TO_TAI, '0, POSIX_MIN, '0);
      send(CMD_POSIX_TO_TAI, '0, TIME_W'(78796799), '0);
      send(CMD_POSIX_TO_TAI, '0, TIME_W'(78796800), '0);
      send(CMD_POSIX_TO_TAI, '0, TIME_W'(200000000), '0);
      send(CMD_POSIX_TO_TAI, '0, TIME_W'(200000001), '0);
      send(CMD_TAI_TO_POSIX, '0, TAI_MIN - 1, '0);
      send(CMD_TAI_TO_POSIX, '0, TAI_MIN, '0);
      send(CMD_TAI_TO_POSIX, '0, TIME_W'(200000013), '0);
      send(CMD_TAI_TO_POSIX, '0, TIME_W'(200000014), '0);
      send(CMD_UNUSED, IDX_W'(TABLE_DEPTH - 1), TIME_MAX, -8'sd128);

      // first entry starts above the value being converted
      send(CMD_LOAD, IDX_W'(0), POSIX_MIN + 5, 8'sd10);
      send(CMD_POSIX_TO_TAI, '0, POSIX_MIN + 2, '0);
      send(CMD_TAI_TO_POSIX, '0, TAI_MIN + 2, '0);

      // saturated TAI limit, and a converted time past full width
      set_config(1, TIME_MAX);
      send(CMD_LOAD, IDX_W'(0), POSIX_MIN, 8'sd127);
      send(CMD_POSIX_TO_TAI, '0, TIME_MAX, '0);
      send(CMD_TAI_TO_POSIX, '0, TIME_MAX, '0);

      // negative TAI limit: nothing converts
      set_config(1, '0);
      send(CMD_LOAD, IDX_W'(0), POSIX_MIN, -8'sd128);
      send(CMD_TAI_TO_POSIX, '0, TAI_MIN, '0);
      send(CMD_POSIX_TO_TAI, '0, POSIX_MIN, '0);

      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         quiet = (phase_no >= 3 && phase_no < 5);
         run_phase(phase_no, (phase_no == 0) ? TABLE_DEPTH : ((phase_no == 1) ? 127 : -1));
         phase_no++;
      end
      quiet = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
